/* rtl/fufe_pkg.sv */
// fufe_pkg: types, codes and character constants for the form field extractor
// no dependencies; used by form_urlencoded_field_extractor
package fufe_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0]  CH_EQ    = 8'h3d;
	localparam logic [7:0]  CH_AMP   = 8'h26;
	localparam logic [7:0]  CH_PLUS  = 8'h2b;
	localparam logic [7:0]  CH_PCT   = 8'h25;
	localparam logic [7:0]  CH_SPACE = 8'h20;
	localparam logic [31:0] KEY_SSID = 32'h64697373;
	localparam logic [31:0] KEY_PASS = 32'h73736170;

	typedef enum logic [1:0] {
		PH_KEY   = 2'd0,
		PH_VALUE = 2'd1,
		PH_ESC1  = 2'd2,
		PH_ESC2  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		TGT_NAME  = 2'd0,
		TGT_PASS  = 2'd1,
		TGT_OTHER = 2'd2
	} target_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_TOO_LONG  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_CHAR   = 2'd0,
		KIND_LENGTH = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_body;
	} body_t;

	typedef struct packed {
		kind_t      kind;
		logic       target;
		logic [5:0] position;
		logic [7:0] char_value;
		logic [6:0] value_length;
		status_t    status;
		logic       final_res;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// hex digit of either case
	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.val = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

/* rtl/form_urlencoded_field_extractor.sv */
// form_urlencoded_field_extractor: streaming ssid/pass extractor for a form body
// depends on fufe_pkg
//
// Takes an application/x-www-form-urlencoded body one byte item per cycle and
// decodes the values of the keys "ssid" and "pass" ('+' to space, %XX to a byte).
// Each decoded character comes out with its target and position, each finished
// value with its length, and the last item of a body is followed by a status
// item (ok, malformed, too long) flagged with final_res. An item is held in
// the input register, then one update of the parser state pushes its results
// (up to three) into a four-entry result queue; the next item is taken in the
// same cycle, so one byte per cycle is sustained while each byte yields at most
// one result and the result side keeps up. A byte that yields more (an end of
// body closing a value) leaves extra results for the output side, which the
// queue absorbs, and the input stalls only while the queue lacks room for three.
// After the status item all parser state returns to its reset values.
module form_urlencoded_field_extractor #(
	parameter int NAME_CAPACITY = 33,
	parameter int PASS_CAPACITY = 65
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            body_valid,
	output logic            body_stall,
	input  fufe_pkg::body_t body,
	output logic            res_valid,
	input  logic            res_stall,
	output fufe_pkg::res_t  res
);

	// index width follows the larger capacity; one extra bit for the compare
	localparam int CAP_MAX = (NAME_CAPACITY > PASS_CAPACITY) ? NAME_CAPACITY : PASS_CAPACITY;
	localparam int IDX_W   = $clog2(CAP_MAX);
	localparam int CMP_W   = IDX_W + 1;
	localparam int EXT_W   = IDX_W + 7;

	// input register
	logic            valid_s1;
	fufe_pkg::body_t body_s1;

	// parser state
	fufe_pkg::phase_t  phase_q, phase_n;
	logic [31:0]       key_bytes_q, key_bytes_n;
	logic [2:0]        key_count_q, key_count_n;
	fufe_pkg::target_t tgt_q, tgt_n;
	logic [IDX_W-1:0]  widx_q, widx_n;
	logic [3:0]        hnib_q, hnib_n;
	logic              name_seen_q, name_seen_n;
	fufe_pkg::status_t err_q, err_n;

	// result queue
	fufe_pkg::res_t              fifo_q [fufe_pkg::FIFO_DEPTH];
	logic [fufe_pkg::PTR_W-1:0]  head_q, tail_q;
	logic [fufe_pkg::CNT_W-1:0]  count_q;

	logic pop, room, advance;

	// per-item decode
	logic [7:0]        b;
	fufe_pkg::hex_t    hx;
	logic              emit_req;
	logic [7:0]        emit_ch;
	logic              fin_byte;
	logic              full;
	logic [CMP_W-1:0]  cap_sel;
	logic [EXT_W-1:0]  idx_ext, len_byte_ext, len_last_ext;
	logic              r_byte_v, r_last_v, r_stat_v;
	fufe_pkg::res_t    r_byte, r_last, r_stat;
	logic [1:0]        push_cnt;
	logic [fufe_pkg::PTR_W-1:0] wr_last, wr_stat;

	// handshakes
	assign pop       = res_valid && !res_stall;
	assign res_valid = (count_q != '0);
	assign res       = fifo_q[head_q];
	// three free entries after this cycle's pop
	assign room      = (count_q <= fufe_pkg::CNT_W'(1)) ||
	                   ((count_q == fufe_pkg::CNT_W'(2)) && pop);
	assign advance   = valid_s1 && room;
	assign body_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body_valid && !body_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (body_valid && !body_stall) begin
			body_s1 <= body;
		end
	end

	// capacity check against the current value's target
	assign cap_sel = (tgt_q == fufe_pkg::TGT_NAME) ? CMP_W'(NAME_CAPACITY)
	                                               : CMP_W'(PASS_CAPACITY);
	assign full    = ({1'b0, widx_q} + CMP_W'(1)) >= cap_sel;
	assign idx_ext = EXT_W'(widx_q);
	assign b       = body_s1.data_byte;
	assign hx      = fufe_pkg::hex_digit(b);

	always_comb begin
		phase_n      = phase_q;
		key_bytes_n  = key_bytes_q;
		key_count_n  = key_count_q;
		tgt_n        = tgt_q;
		widx_n       = widx_q;
		hnib_n       = hnib_q;
		name_seen_n  = name_seen_q;
		err_n        = err_q;
		emit_req     = 1'b0;
		emit_ch      = 8'd0;
		fin_byte     = 1'b0;
		r_byte_v     = 1'b0;
		r_byte       = '0;
		r_last_v     = 1'b0;
		r_last       = '0;
		r_stat       = '0;
		len_last_ext = '0;

		// byte part
		if (body_s1.byte_present && err_q == fufe_pkg::ST_OK) begin
			if (phase_q == fufe_pkg::PH_KEY) begin
				if (b == fufe_pkg::CH_EQ) begin
					if (key_count_q == 3'd4 && key_bytes_q == fufe_pkg::KEY_SSID) begin
						tgt_n = fufe_pkg::TGT_NAME;
					end else if (key_count_q == 3'd4 && key_bytes_q == fufe_pkg::KEY_PASS) begin
						tgt_n = fufe_pkg::TGT_PASS;
					end else begin
						tgt_n = fufe_pkg::TGT_OTHER;
					end
					widx_n  = '0;
					phase_n = fufe_pkg::PH_VALUE;
				end else if (key_count_q < 3'd4) begin
					key_bytes_n[key_count_q[1:0]*8 +: 8] = b;
					key_count_n = key_count_q + 3'd1;
				end else begin
					key_count_n = 3'd5;
				end
			end else if (b == fufe_pkg::CH_AMP) begin
				if (phase_q == fufe_pkg::PH_VALUE) begin
					fin_byte    = (tgt_q != fufe_pkg::TGT_OTHER);
					if (tgt_q == fufe_pkg::TGT_NAME) begin
						name_seen_n = 1'b1;
					end
					key_bytes_n = '0;
					key_count_n = '0;
					phase_n     = fufe_pkg::PH_KEY;
				end else begin
					// escape cut short
					err_n = fufe_pkg::ST_MALFORMED;
				end
			end else if (phase_q == fufe_pkg::PH_VALUE) begin
				if (tgt_q != fufe_pkg::TGT_OTHER) begin
					if (b == fufe_pkg::CH_PLUS) begin
						emit_req = 1'b1;
						emit_ch  = fufe_pkg::CH_SPACE;
					end else if (b == fufe_pkg::CH_PCT) begin
						phase_n = fufe_pkg::PH_ESC1;
					end else begin
						emit_req = 1'b1;
						emit_ch  = b;
					end
				end
			end else begin
				if (!hx.ok) begin
					err_n = fufe_pkg::ST_MALFORMED;
				end else if (phase_q == fufe_pkg::PH_ESC1) begin
					hnib_n  = hx.val;
					phase_n = fufe_pkg::PH_ESC2;
				end else begin
					phase_n  = fufe_pkg::PH_VALUE;
					emit_req = 1'b1;
					emit_ch  = {hnib_q, hx.val};
				end
			end
		end

		// place a decoded character or latch too long, or give a finished value's length
		if (emit_req) begin
			if (full) begin
				err_n = fufe_pkg::ST_TOO_LONG;
			end else begin
				r_byte_v          = 1'b1;
				r_byte.kind       = fufe_pkg::KIND_CHAR;
				r_byte.target     = tgt_q[0];
				r_byte.position   = idx_ext[5:0];
				r_byte.char_value = emit_ch;
				widx_n            = widx_q + IDX_W'(1);
			end
		end else if (fin_byte) begin
			r_byte_v            = 1'b1;
			r_byte.kind         = fufe_pkg::KIND_LENGTH;
			r_byte.target       = tgt_q[0];
			r_byte.value_length = len_byte_ext[6:0];
		end

		// end of body: close an open value, then the status
		r_stat_v = body_s1.end_of_body;
		if (body_s1.end_of_body) begin
			if (err_n == fufe_pkg::ST_OK) begin
				if (phase_n == fufe_pkg::PH_ESC1 || phase_n == fufe_pkg::PH_ESC2) begin
					err_n = fufe_pkg::ST_MALFORMED;
				end else if (phase_n == fufe_pkg::PH_VALUE &&
				             tgt_n != fufe_pkg::TGT_OTHER) begin
					// length at end of body uses the index after this byte
					len_last_ext        = EXT_W'(widx_n);
					r_last_v            = 1'b1;
					r_last.kind         = fufe_pkg::KIND_LENGTH;
					r_last.target       = tgt_n[0];
					r_last.value_length = len_last_ext[6:0];
					if (tgt_n == fufe_pkg::TGT_NAME) begin
						name_seen_n = 1'b1;
					end
				end
			end
			r_stat.kind      = fufe_pkg::KIND_STATUS;
			r_stat.final_res = 1'b1;
			if (err_n != fufe_pkg::ST_OK) begin
				r_stat.status = err_n;
			end else begin
				r_stat.status = name_seen_n ? fufe_pkg::ST_OK : fufe_pkg::ST_MALFORMED;
			end
			// back to reset for the next body
			phase_n     = fufe_pkg::PH_KEY;
			key_bytes_n = '0;
			key_count_n = '0;
			tgt_n       = fufe_pkg::TGT_OTHER;
			widx_n      = '0;
			hnib_n      = '0;
			name_seen_n = 1'b0;
			err_n       = fufe_pkg::ST_OK;
		end
	end

	assign len_byte_ext = EXT_W'(widx_q);

	assign push_cnt = 2'(r_byte_v) + 2'(r_last_v) + 2'(r_stat_v);
	assign wr_last  = tail_q + fufe_pkg::PTR_W'(r_byte_v);
	assign wr_stat  = tail_q + fufe_pkg::PTR_W'(r_byte_v) + fufe_pkg::PTR_W'(r_last_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= fufe_pkg::PH_KEY;
			key_bytes_q <= '0;
			key_count_q <= '0;
			tgt_q       <= fufe_pkg::TGT_OTHER;
			widx_q      <= '0;
			hnib_q      <= '0;
			name_seen_q <= 1'b0;
			err_q       <= fufe_pkg::ST_OK;
		end else if (advance) begin
			phase_q     <= phase_n;
			key_bytes_q <= key_bytes_n;
			key_count_q <= key_count_n;
			tgt_q       <= tgt_n;
			widx_q      <= widx_n;
			hnib_q      <= hnib_n;
			name_seen_q <= name_seen_n;
			err_q       <= err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + fufe_pkg::PTR_W'(1);
			end
			if (advance) begin
				tail_q <= tail_q + fufe_pkg::PTR_W'(push_cnt);
			end
			count_q <= count_q + (advance ? fufe_pkg::CNT_W'(push_cnt) : '0)
			                   - fufe_pkg::CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (r_byte_v) begin
				fifo_q[tail_q] <= r_byte;
			end
			if (r_last_v) begin
				fifo_q[wr_last] <= r_last;
			end
			if (r_stat_v) begin
				fifo_q[wr_stat] <= r_stat;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fufe_pkg::CNT_W'(fufe_pkg::FIFO_DEPTH))
		else $error("result queue overfilled");

	a_final_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.final_res |-> res.kind == fufe_pkg::KIND_STATUS)
		else $error("final flag on a non-status item");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && body_s1.end_of_body |=>
		phase_q == fufe_pkg::PH_KEY && key_count_q == '0 &&
		err_q == fufe_pkg::ST_OK && !name_seen_q)
		else $error("parser state not cleared after end of body");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != fufe_pkg::ST_OK && !(advance && body_s1.end_of_body) |=> $stable(err_q))
		else $error("latched error changed before end of body");
`endif

endmodule

/* bench/tb_form_urlencoded_field_extractor.sv */
// tb_form_urlencoded_field_extractor: self-checking bench for the form field extractor
// depends on fufe_pkg and form_urlencoded_field_extractor; runs directed and random
// form bodies through both handshakes and checks every result item against a predictor
`timescale 1ns / 100ps

module tb_form_urlencoded_field_extractor;

	localparam int NAME_CAP    = 33;
	localparam int PASS_CAP    = 65;
	localparam int STUCK_LIMIT = 2000;	// cycles with no item moving while work is pending
	localparam int TAIL_CYCLES = 20;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            body_valid;
	logic            body_stall;
	fufe_pkg::body_t body;
	logic            res_valid;
	logic            res_stall;
	fufe_pkg::res_t  res;

	form_urlencoded_field_extractor #(
		.NAME_CAPACITY(NAME_CAP),
		.PASS_CAPACITY(PASS_CAP)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.body_valid(body_valid),
		.body_stall(body_stall),
		.body      (body),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// parser mirror: state and the queue of result items it predicts
	// ------------------------------------------------------------------
	fufe_pkg::phase_t  ph;
	logic [31:0]       key_word;	// first four key bytes, first byte lowest
	int                key_len;	// saturates at 5
	fufe_pkg::target_t tgt;
	int                wr_idx;
	logic [3:0]        hi_nib;
	bit                name_seen;
	fufe_pkg::status_t err;		// ST_OK means nothing latched

	fufe_pkg::res_t   decoded_q[$];	// result items still to come, oldest first
	fufe_pkg::body_t  body_q[$];	// body being assembled for sending
	int               fails = 0;
	int               items_sent = 0;
	int               send_idle_pct = 0;
	int               stall_pct = 0;
	bit               noise_on = 1'b0;
	fufe_pkg::res_t   want_res;

	function automatic void clear_parser();
		ph        = fufe_pkg::PH_KEY;
		key_word  = '0;
		key_len   = 0;
		tgt       = fufe_pkg::TGT_OTHER;
		wr_idx    = 0;
		hi_nib    = '0;
		name_seen = 1'b0;
		err       = fufe_pkg::ST_OK;
	endfunction

	function automatic void push_res(fufe_pkg::kind_t k, logic t, int pos, logic [7:0] ch,
			int len, fufe_pkg::status_t st, logic fin);
		fufe_pkg::res_t r;
		r.kind         = k;
		r.target       = t;
		r.position     = 6'(pos);
		r.char_value   = ch;
		r.value_length = 7'(len);
		r.status       = st;
		r.final_res    = fin;
		decoded_q.push_back(r);
	endfunction

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
		return -1;
	endfunction

	// a decoded character lands only if a terminator still fits behind it
	function automatic void place_char(input logic [7:0] ch);
		int cap;
		cap = (tgt == fufe_pkg::TGT_NAME) ? NAME_CAP : PASS_CAP;
		if (wr_idx + 1 >= cap) begin
			err = fufe_pkg::ST_TOO_LONG;
		end else begin
			push_res(fufe_pkg::KIND_CHAR, tgt[0], wr_idx, ch, 0, fufe_pkg::ST_OK, 1'b0);
			wr_idx++;
		end
	endfunction

	function automatic void close_value();
		if (tgt != fufe_pkg::TGT_OTHER) begin
			push_res(fufe_pkg::KIND_LENGTH, tgt[0], 0, 8'h00, wr_idx, fufe_pkg::ST_OK, 1'b0);
			if (tgt == fufe_pkg::TGT_NAME) name_seen = 1'b1;
		end
	endfunction

	// one accepted body item: update the mirror and queue what it yields
	function automatic void decode_item(input fufe_pkg::body_t it);
		logic [7:0]        b;
		int                d;
		fufe_pkg::status_t st;
		b = it.data_byte;
		if (it.byte_present && err == fufe_pkg::ST_OK) begin
			if (ph == fufe_pkg::PH_KEY) begin
				if (b == fufe_pkg::CH_EQ) begin
					if (key_len == 4 && key_word == fufe_pkg::KEY_SSID) begin
						tgt = fufe_pkg::TGT_NAME;
					end else if (key_len == 4 && key_word == fufe_pkg::KEY_PASS) begin
						tgt = fufe_pkg::TGT_PASS;
					end else begin
						tgt = fufe_pkg::TGT_OTHER;
					end
					wr_idx = 0;
					ph = fufe_pkg::PH_VALUE;
				end else if (key_len < 4) begin
					key_word[8*key_len +: 8] = b;
					key_len++;
				end else begin
					key_len = 5;
				end
			end else if (b == fufe_pkg::CH_AMP) begin
				if (ph == fufe_pkg::PH_VALUE) begin
					close_value();
					key_word = '0;
					key_len = 0;
					ph = fufe_pkg::PH_KEY;
				end else begin
					// escape cut short by a separator
					err = fufe_pkg::ST_MALFORMED;
				end
			end else if (ph == fufe_pkg::PH_VALUE) begin
				// values of other keys are skipped, escapes included
				if (tgt != fufe_pkg::TGT_OTHER) begin
					if (b == fufe_pkg::CH_PLUS) place_char(fufe_pkg::CH_SPACE);
					else if (b == fufe_pkg::CH_PCT) ph = fufe_pkg::PH_ESC1;
					else place_char(b);
				end
			end else begin
				d = hex_nibble(b);
				if (d < 0) begin
					err = fufe_pkg::ST_MALFORMED;
				end else if (ph == fufe_pkg::PH_ESC1) begin
					hi_nib = d[3:0];
					ph = fufe_pkg::PH_ESC2;
				end else begin
					ph = fufe_pkg::PH_VALUE;
					place_char({hi_nib, d[3:0]});
				end
			end
		end
		if (it.end_of_body) begin
			if (err == fufe_pkg::ST_OK) begin
				if (ph == fufe_pkg::PH_ESC1 || ph == fufe_pkg::PH_ESC2) begin
					err = fufe_pkg::ST_MALFORMED;
				end else if (ph == fufe_pkg::PH_VALUE) begin
					close_value();
				end
			end
			if (err != fufe_pkg::ST_OK) st = err;
			else st = name_seen ? fufe_pkg::ST_OK : fufe_pkg::ST_MALFORMED;
			push_res(fufe_pkg::KIND_STATUS, 1'b0, 0, 8'h00, 0, st, 1'b1);
			clear_parser();
		end
	endfunction

	// ------------------------------------------------------------------
	// result side: random stall, checking of every accepted result item
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		res_stall = ($urandom_range(99) < stall_pct);
	end

	function automatic void report_field(input string name, input int want, input int got);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		fails++;
	endfunction

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected result item, expected none, got %h", $time, res);
				fails++;
			end else begin
				want_res = decoded_q.pop_front();
				if (res.kind !== want_res.kind)
					report_field("kind", want_res.kind, res.kind);
				if (res.target !== want_res.target)
					report_field("target", want_res.target, res.target);
				if (res.position !== want_res.position)
					report_field("position", want_res.position, res.position);
				if (res.char_value !== want_res.char_value)
					report_field("char_value", want_res.char_value, res.char_value);
				if (res.value_length !== want_res.value_length)
					report_field("value_length", want_res.value_length, res.value_length);
				if (res.status !== want_res.status)
					report_field("status", want_res.status, res.status);
				if (res.final_res !== want_res.final_res)
					report_field("final_res", want_res.final_res, res.final_res);
			end
		end
	end

	// ends the run when nothing moves on either side while work is pending
	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((body_valid && !body_stall) || (res_valid && !res_stall)) stuck = 0;
			else if (body_valid || decoded_q.size() != 0) stuck++;
		end
		$display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
		$display("tb_form_urlencoded_field_extractor failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// body assembly
	// ------------------------------------------------------------------
	// bare item: end marker when last is set, otherwise ignored by the block
	task automatic add_marker(input bit last);
		fufe_pkg::body_t it;
		it.data_byte    = 8'($urandom_range(255));
		it.byte_present = 1'b0;
		it.end_of_body  = last;
		body_q.push_back(it);
	endtask

	task automatic add_byte(input logic [7:0] b);
		fufe_pkg::body_t it;
		if (noise_on && $urandom_range(99) < 3) add_marker(1'b0);
		it.data_byte    = b;
		it.byte_present = 1'b1;
		it.end_of_body  = 1'b0;
		body_q.push_back(it);
	endtask

	task automatic add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) add_byte(s[i]);
	endtask

	// the last queued item becomes the end of the body
	task automatic set_end();
		fufe_pkg::body_t it;
		it = body_q.pop_back();
		it.end_of_body = 1'b1;
		body_q.push_back(it);
	endtask

	function automatic logic [7:0] hex_char(input int v);
		if (v < 10) return 8'(48 + v);
		return 8'(($urandom_range(1) != 0 ? 65 : 97) + v - 10);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (c == fufe_pkg::CH_AMP || c == fufe_pkg::CH_PCT);
		return c;
	endfunction

	function automatic logic [7:0] bad_hex_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (hex_nibble(c) >= 0 || c == fufe_pkg::CH_AMP);
		return c;
	endfunction

	function automatic logic [7:0] key_byte();
		logic [7:0] c;
		if ($urandom_range(9) == 0) return fufe_pkg::CH_AMP;	// keys may hold '&'
		do c = 8'($urandom_range(255)); while (c == fufe_pkg::CH_EQ);
		return c;
	endfunction

	// mostly the two decoded keys, plus near misses and junk
	task automatic add_key(output fufe_pkg::target_t t);
		int          sel;
		int          n;
		int          i;
		logic [31:0] word;
		sel  = $urandom_range(99);
		word = ($urandom_range(1) != 0) ? fufe_pkg::KEY_SSID : fufe_pkg::KEY_PASS;
		t    = fufe_pkg::TGT_OTHER;
		if (sel < 70) begin
			word = (sel < 35) ? fufe_pkg::KEY_SSID : fufe_pkg::KEY_PASS;
			t    = (sel < 35) ? fufe_pkg::TGT_NAME : fufe_pkg::TGT_PASS;
			for (i = 0; i < 4; i++) add_byte(word[8*i +: 8]);
		end else if (sel < 80) begin
			// prefix, possibly empty
			n = $urandom_range(3);
			for (i = 0; i < n; i++) add_byte(word[8*i +: 8]);
		end else if (sel < 88) begin
			// right key with extra bytes behind it
			for (i = 0; i < 4; i++) add_byte(word[8*i +: 8]);
			n = $urandom_range(1, 2);
			for (i = 0; i < n; i++) add_byte(key_byte());
		end else if (sel < 94) begin
			// one byte replaced
			n = $urandom_range(3);
			for (i = 0; i < 4; i++) add_byte(i == n ? key_byte() : word[8*i +: 8]);
		end else begin
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++) add_byte(key_byte());
		end
	endtask

	// short values mostly; now and then one right at the capacity edge
	task automatic add_value(input fufe_pkg::target_t t);
		int cap;
		int len;
		int i;
		int sel;
		bit long_val;
		cap      = (t == fufe_pkg::TGT_NAME) ? NAME_CAP : PASS_CAP;
		long_val = (t != fufe_pkg::TGT_OTHER) && ($urandom_range(99) < 15);
		len      = long_val ? $urandom_range(cap - 3, cap + 1) : $urandom_range(6);
		for (i = 0; i < len; i++) begin
			sel = $urandom_range(99);
			if (sel < 10) begin
				add_byte(fufe_pkg::CH_PLUS);
			end else if (sel < 30) begin
				add_byte(fufe_pkg::CH_PCT);
				add_byte(hex_char($urandom_range(15)));
				add_byte(hex_char($urandom_range(15)));
			end else if (sel < 33 && !long_val) begin
				// bad digit in first or second place
				add_byte(fufe_pkg::CH_PCT);
				if ($urandom_range(1) != 0) add_byte(hex_char($urandom_range(15)));
				add_byte(bad_hex_byte());
			end else begin
				add_byte(plain_byte());
			end
		end
		// escape cut short by the separator or the end of the body
		if (!long_val && $urandom_range(99) < 4) begin
			add_byte(fufe_pkg::CH_PCT);
			if ($urandom_range(1) != 0) add_byte(hex_char($urandom_range(15)));
		end
	endtask

	task automatic build_body();
		int                nf;
		int                f;
		int                i;
		fufe_pkg::target_t t;
		body_q.delete();
		if ($urandom_range(99) < 8) begin
			// raw noise body
			nf = $urandom_range(1, 10);
			for (i = 0; i < nf; i++) add_byte(8'($urandom_range(255)));
		end else begin
			nf = $urandom_range(1, 4);
			for (f = 0; f < nf; f++) begin
				if (f > 0) add_byte(fufe_pkg::CH_AMP);
				add_key(t);
				// a trailing key without '=' is dropped by the block
				if (!(f == nf - 1 && $urandom_range(99) < 8)) begin
					add_byte(fufe_pkg::CH_EQ);
					add_value(t);
				end
			end
		end
		if (body_q.size() == 0 || $urandom_range(99) < 30) add_marker(1'b1);
		else set_end();
	endtask

	// ------------------------------------------------------------------
	// sending: inputs change on the falling edge, acceptance seen on the rising
	// ------------------------------------------------------------------
	// called on a falling edge; returns on the falling edge after acceptance
	// with valid still high, so back-to-back items need no drop in between
	task automatic send_item(input fufe_pkg::body_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			body_valid = 1'b0;
			@(negedge clk);
		end
		body_valid = 1'b1;
		body       = it;
		do @(posedge clk); while (body_stall);
		decode_item(it);
		@(negedge clk);
	endtask

	task automatic send_body();
		int i;
		for (i = 0; i < body_q.size(); i++) begin
			send_item(body_q[i]);
			if (body_q[i].byte_present || body_q[i].end_of_body) items_sent++;
		end
		body_valid = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// empty body, escapes of both cases, byte extremes, bare marker mid body,
	// truncated escape, escape in a skipped value
	task automatic test_directed_cases();
		noise_on      = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		body_q.delete();
		add_marker(1'b1);		// empty body: no ssid, so malformed
		add_text("ssid=");
		add_marker(1'b0);		// ignored, no result
		add_text("%4a+");
		add_byte(8'h00);
		set_end();			// ok with three characters
		add_text("pass=");
		add_byte(8'hff);
		add_text("%F");
		set_end();			// escape cut by the end: malformed
		add_text("=%g");
		set_end();			// escape in an empty key's value is skipped
		send_body();
	endtask

	task automatic test_random_bodies(input int idle_pct, input int stall_in, input int n);
		int stop_at;
		noise_on      = 1'b1;
		send_idle_pct = idle_pct;
		stall_pct     = stall_in;
		stop_at       = items_sent + n;
		while (items_sent < stop_at) begin
			build_body();
			send_body();
		end
	endtask

	// sender holds off until every predicted result item is out
	task automatic test_drain_pause();
		noise_on      = 1'b1;
		send_idle_pct = 0;
		stall_pct     = 30;
		build_body();
		send_body();
		while (decoded_q.size() != 0) @(negedge clk);
		build_body();
		send_body();
	endtask

	initial begin
		arst_n     = 1'b0;
		body_valid = 1'b0;
		body       = '0;
		res_stall  = 1'b0;
		clear_parser();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_random_bodies(0, 0, 90);		// full rate
		test_random_bodies(70, 0, 90);		// sparse input
		test_drain_pause();
		test_random_bodies(0, 70, 90);		// heavy back pressure
		test_random_bodies(7, 7, 90);		// light jitter on both sides

		stall_pct = 0;
		while (decoded_q.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fails == 0) begin
			$display("tb_form_urlencoded_field_extractor passed");
		end else begin
			$display("tb_form_urlencoded_field_extractor failed");
		end
		$finish;
	end

endmodule
